>>> src/surface_normal_from_tangents_unit_assert.svh
// Assertion macros shared by the surface normal unit RTL.
// Depends on clk_i and rst_ni being declared in the including module.
`ifndef SURFACE_NORMAL_FROM_TANGENTS_UNIT_ASSERT_SVH
`define SURFACE_NORMAL_FROM_TANGENTS_UNIT_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define SNFT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising clock edge out of reset.
`define SNFT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/snft_pkg.sv
// Package of the surface normal unit: widths, reset values and codes.
// No dependencies; the other files that use it refer to it by scoped names.
package snft_pkg;

  localparam int COMPONENT_BITS_DEF = 24;
  localparam int NORMAL_BITS        = 32;
  localparam int ROOT_BITS          = 32;
  localparam int ROOT_SHIFT         = 62;
  localparam int TOL_BITS           = 16;
  localparam int TOL_SQ_BITS        = 2 * TOL_BITS;
  localparam int THR_BITS           = 48;
  localparam int APB_DATA_BITS      = 64;
  localparam int APB_ADDR_BITS      = 4;
  localparam int APB_SEL_BIT        = 3;

  localparam logic [TOL_BITS-1:0] SIN_TOL_RESET  = 16'd66;
  localparam logic [THR_BITS-1:0] NULL_THR_RESET = '0;

  localparam logic signed [NORMAL_BITS-1:0] UNIT_ONE = 32'sd1073741824;

  typedef enum logic [2:0] {
    ST_DONE      = 3'd0,
    ST_BOTH_NULL = 3'd1,
    ST_U_NULL    = 3'd2,
    ST_V_NULL    = 3'd3,
    ST_PARALLEL  = 3'd4
  } status_e;

  typedef enum logic {
    REG_SIN_TOL  = 1'b0,
    REG_NULL_THR = 1'b1
  } cfg_reg_e;

endpackage

>>> src/snft_if.sv
// Stream interfaces of the surface normal unit: tangent pairs in, normals out.
// Depends on snft_pkg for the status type and the normal width.
interface snft_in_if #(
  parameter int CB = snft_pkg::COMPONENT_BITS_DEF
);
  logic          valid;
  logic          ready;
  logic signed [CB-1:0] du_x;
  logic signed [CB-1:0] du_y;
  logic signed [CB-1:0] du_z;
  logic signed [CB-1:0] dv_x;
  logic signed [CB-1:0] dv_y;
  logic signed [CB-1:0] dv_z;

  modport source (output valid, du_x, du_y, du_z, dv_x, dv_y, dv_z, input ready);
  modport sink   (input valid, du_x, du_y, du_z, dv_x, dv_y, dv_z, output ready);
endinterface

interface snft_out_if;
  logic                                     valid;
  logic                                     ready;
  snft_pkg::status_e                        status;
  logic signed [snft_pkg::NORMAL_BITS-1:0] normal_x;
  logic signed [snft_pkg::NORMAL_BITS-1:0] normal_y;
  logic signed [snft_pkg::NORMAL_BITS-1:0] normal_z;

  modport source (output valid, status, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, status, normal_x, normal_y, normal_z, output ready);
endinterface

>>> src/snft_mul.sv
// Two-stage unsigned multiplier built from narrow partial products.
// Depends on nothing but its parameters.
module snft_mul #(
  parameter int AW = 48,
  parameter int BW = 48,
  parameter int CW = 24
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [AW-1:0]      a_i,
  input  logic [BW-1:0]      b_i,
  output logic [AW+BW-1:0]   p_o
);

  localparam int NA   = (AW + CW - 1) / CW;
  localparam int NB   = (BW + CW - 1) / CW;
  localparam int SUMW = (NA + NB) * CW;

  logic [NA*CW-1:0]  a_pad;
  logic [NB*CW-1:0]  b_pad;
  logic [2*CW-1:0]   pp_q [NA][NB];
  logic [SUMW-1:0]   sum;
  logic [AW+BW-1:0]  p_q;

  assign a_pad = (NA*CW)'(a_i);
  assign b_pad = (NB*CW)'(b_i);

  // First stage: every chunk pair multiplied on its own.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_q[i][j] <= a_pad[i*CW +: CW] * b_pad[j*CW +: CW];
        end
      end
    end
  end

  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SUMW'(pp_q[i][j]) << (CW * (i + j)));
      end
    end
  end

  // Second stage: aligned partial products summed.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= sum[AW+BW-1:0];
    end
  end

  assign p_o = p_q;

endmodule

>>> src/snft_root_lane.sv
// Pipelined bit-by-bit search for the largest y with y^2 * s <= x * 2^62.
// Depends on snft_pkg for the root width and the fixed shift of x.
module snft_root_lane #(
  parameter int SW = 96,
  parameter int TW = 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [SW-1:0]                 x_i,
  input  logic [SW-1:0]                 s_i,
  input  logic [TW-1:0]                 tag_i,
  output logic                          valid_o,
  output logic [snft_pkg::ROOT_BITS-1:0] y_o,
  output logic [TW-1:0]                 tag_o
);

  localparam int QB = snft_pkg::ROOT_BITS;
  localparam int PW = SW + QB;
  localparam int AW = SW + 2 * QB + 2;

  logic [AW-1:0] r_q [QB];
  logic [PW-1:0] p_q [QB];
  logic [QB-1:0] y_q [QB];
  logic [SW-1:0] s_q [QB];
  logic [TW-1:0] t_q [QB];
  logic          v_q [QB];

  for (genvar j = 0; j < QB; j++) begin : g_stage
    localparam int K = QB - 1 - j;

    logic [AW-1:0] r_in;
    logic [PW-1:0] p_in;
    logic [QB-1:0] y_in;
    logic [SW-1:0] s_in;
    logic [TW-1:0] t_in;
    logic          v_in;
    logic [AW-1:0] addend;
    logic          take;

    if (j == 0) begin : g_first
      assign r_in = AW'(x_i) << snft_pkg::ROOT_SHIFT;
      assign p_in = '0;
      assign y_in = '0;
      assign s_in = s_i;
      assign t_in = tag_i;
      assign v_in = valid_i;
    end else begin : g_next
      assign r_in = r_q[j-1];
      assign p_in = p_q[j-1];
      assign y_in = y_q[j-1];
      assign s_in = s_q[j-1];
      assign t_in = t_q[j-1];
      assign v_in = v_q[j-1];
    end

    // (y + 2^K)^2 s - y^2 s = 2^(K+1) (y s) + 2^(2K) s, with y s kept in p.
    assign addend = (AW'(p_in) << (K + 1)) + (AW'(s_in) << (2 * K));
    assign take   = (addend <= r_in);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (en_i) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[j] <= take ? (r_in - addend) : r_in;
        p_q[j] <= take ? (p_in + (PW'(s_in) << K)) : p_in;
        y_q[j] <= take ? (y_in | (QB'(1) << K)) : y_in;
        s_q[j] <= s_in;
        t_q[j] <= t_in;
      end
    end
  end

  assign valid_o = v_q[QB-1];
  assign y_o     = y_q[QB-1];
  assign tag_o   = t_q[QB-1];

endmodule

>>> src/surface_normal_from_tangents_unit.sv
// Top level of the surface normal unit: cross product, tests and unit normal.
// Depends on snft_pkg, snft_if, snft_mul, snft_root_lane and the assert header.
//
//  Channel     Direction  Handshake          Payload
//  in_chan_i   in         valid/ready        du_x du_y du_z dv_x dv_y dv_z
//  out_chan_o  out        valid/ready        status normal_x normal_y normal_z
//  APB         in         psel/penable       sin_tol (0x0), null_threshold (0x8)
//
// One transaction enters per cycle while the output is not stalled; results leave in order.
// The pipeline runs through seven stages of products, squares and the parallel test,
// then the 32 one-bit stages of the normalizing root search and the output register.
// rst_ni clears all valid bits and loads the register reset values.
// A stall on the output freezes the whole pipeline; input ready drops with it.
`include "surface_normal_from_tangents_unit_assert.svh"

module surface_normal_from_tangents_unit #(
  parameter int COMPONENT_BITS = snft_pkg::COMPONENT_BITS_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  snft_in_if.sink                                in_chan_i,
  snft_out_if.source                             out_chan_o,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [snft_pkg::APB_ADDR_BITS-1:0]     paddr,
  input  logic [snft_pkg::APB_DATA_BITS-1:0]     pwdata,
  output logic [snft_pkg::APB_DATA_BITS-1:0]     prdata,
  output logic                                   pready
);

  localparam int CB   = COMPONENT_BITS;
  localparam int LW   = 2 * CB;
  localparam int SQW  = 4 * CB;
  localparam int TLW  = SQW + snft_pkg::TOL_SQ_BITS;
  localparam int CMPW = (LW > snft_pkg::THR_BITS) ? LW : snft_pkg::THR_BITS;
  localparam int QB   = snft_pkg::ROOT_BITS;
  localparam int NB   = snft_pkg::NORMAL_BITS;

  // ---------------------------------------------------------------------
  // Configuration registers. Writes land in the access cycle; address bit
  // three picks the register, so every write maps to one of the two.
  // ---------------------------------------------------------------------
  logic [snft_pkg::TOL_BITS-1:0] sin_tol_q;
  logic [snft_pkg::THR_BITS-1:0] null_thr_q;
  snft_pkg::cfg_reg_e            cfg_sel;

  assign cfg_sel = snft_pkg::cfg_reg_e'(paddr[snft_pkg::APB_SEL_BIT]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sin_tol_q  <= snft_pkg::SIN_TOL_RESET;
      null_thr_q <= snft_pkg::NULL_THR_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        snft_pkg::REG_SIN_TOL:  sin_tol_q  <= pwdata[snft_pkg::TOL_BITS-1:0];
        snft_pkg::REG_NULL_THR: null_thr_q <= pwdata[snft_pkg::THR_BITS-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      snft_pkg::REG_SIN_TOL:  prdata = snft_pkg::APB_DATA_BITS'(sin_tol_q);
      snft_pkg::REG_NULL_THR: prdata = snft_pkg::APB_DATA_BITS'(null_thr_q);
    endcase
  end

  // ---------------------------------------------------------------------
  // Pipeline enable. Every stage moves together unless a finished result
  // is waiting on the output register.
  // ---------------------------------------------------------------------
  logic out_v_q;
  logic pipe_en;

  assign pipe_en         = !out_v_q || out_chan_o.ready;
  assign in_chan_i.ready = pipe_en;

  // ---------------------------------------------------------------------
  // Stage A: the six cross-product terms and the six component squares.
  // ---------------------------------------------------------------------
  logic                 a_v_q;
  logic signed [LW-1:0] a_cr_q [6];
  logic signed [LW-1:0] a_sq_q [6];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
    end else if (pipe_en) begin
      a_v_q <= in_chan_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      a_cr_q[0] <= in_chan_i.du_y * in_chan_i.dv_z;
      a_cr_q[1] <= in_chan_i.du_z * in_chan_i.dv_y;
      a_cr_q[2] <= in_chan_i.du_z * in_chan_i.dv_x;
      a_cr_q[3] <= in_chan_i.du_x * in_chan_i.dv_z;
      a_cr_q[4] <= in_chan_i.du_x * in_chan_i.dv_y;
      a_cr_q[5] <= in_chan_i.du_y * in_chan_i.dv_x;
      a_sq_q[0] <= in_chan_i.du_x * in_chan_i.du_x;
      a_sq_q[1] <= in_chan_i.du_y * in_chan_i.du_y;
      a_sq_q[2] <= in_chan_i.du_z * in_chan_i.du_z;
      a_sq_q[3] <= in_chan_i.dv_x * in_chan_i.dv_x;
      a_sq_q[4] <= in_chan_i.dv_y * in_chan_i.dv_y;
      a_sq_q[5] <= in_chan_i.dv_z * in_chan_i.dv_z;
    end
  end

  // ---------------------------------------------------------------------
  // Stage B: cross components as sign and magnitude, squared lengths and
  // the two null tests.
  // ---------------------------------------------------------------------
  logic signed [LW:0] b_c    [3];
  logic [LW:0]        b_mag  [3];
  logic [LW+1:0]      lu_sum;
  logic [LW+1:0]      lv_sum;
  logic               u_null;
  logic               v_null;
  snft_pkg::status_e  b_st;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      b_c[i]   = {a_cr_q[2*i][LW-1], a_cr_q[2*i]} - {a_cr_q[2*i+1][LW-1], a_cr_q[2*i+1]};
      b_mag[i] = b_c[i][LW] ? $unsigned(-b_c[i]) : $unsigned(b_c[i]);
    end
    lu_sum = (LW+2)'($unsigned(a_sq_q[0])) + (LW+2)'($unsigned(a_sq_q[1]))
           + (LW+2)'($unsigned(a_sq_q[2]));
    lv_sum = (LW+2)'($unsigned(a_sq_q[3])) + (LW+2)'($unsigned(a_sq_q[4]))
           + (LW+2)'($unsigned(a_sq_q[5]));
    u_null = CMPW'(lu_sum[LW-1:0]) <= CMPW'(null_thr_q);
    v_null = CMPW'(lv_sum[LW-1:0]) <= CMPW'(null_thr_q);
    if (u_null && v_null) begin
      b_st = snft_pkg::ST_BOTH_NULL;
    end else if (u_null) begin
      b_st = snft_pkg::ST_U_NULL;
    end else if (v_null) begin
      b_st = snft_pkg::ST_V_NULL;
    end else begin
      b_st = snft_pkg::ST_DONE;
    end
  end

  logic              b_v_q;
  logic [LW-1:0]     b_cm_q  [3];
  logic [2:0]        b_sgn_q;
  logic [LW-1:0]     b_lu_q;
  logic [LW-1:0]     b_lv_q;
  snft_pkg::status_e b_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_v_q <= 1'b0;
    end else if (pipe_en) begin
      b_v_q <= a_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      for (int i = 0; i < 3; i++) begin
        b_cm_q[i]  <= b_mag[i][LW-1:0];
        b_sgn_q[i] <= b_c[i][LW];
      end
      b_lu_q <= lu_sum[LW-1:0];
      b_lv_q <= lv_sum[LW-1:0];
      b_st_q <= b_st;
    end
  end

  // ---------------------------------------------------------------------
  // Stages C and D: squared cross magnitudes and the product of lengths.
  // ---------------------------------------------------------------------
  logic [SQW-1:0] d_sq [3];
  logic [SQW-1:0] d_lulv;

  for (genvar i = 0; i < 3; i++) begin : g_sq
    snft_mul #(.AW(LW), .BW(LW), .CW(CB)) u_sq (
      .clk_i (clk_i),
      .en_i  (pipe_en),
      .a_i   (b_cm_q[i]),
      .b_i   (b_cm_q[i]),
      .p_o   (d_sq[i])
    );
  end

  snft_mul #(.AW(LW), .BW(LW), .CW(CB)) u_lulv (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .a_i   (b_lu_q),
    .b_i   (b_lv_q),
    .p_o   (d_lulv)
  );

  logic              c_v_q, d_v_q;
  logic [2:0]        c_sgn_q, d_sgn_q;
  snft_pkg::status_e c_st_q, d_st_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else if (pipe_en) begin
      c_v_q <= b_v_q;
      d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      c_sgn_q <= b_sgn_q;
      c_st_q  <= b_st_q;
      d_sgn_q <= c_sgn_q;
      d_st_q  <= c_st_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stages E and F: squared cross length s, and sin_tol^2 * Lu * Lv.
  // ---------------------------------------------------------------------
  logic [snft_pkg::TOL_SQ_BITS-1:0] tol_sq;
  logic [SQW+1:0]                   s_sum;
  logic [TLW-1:0]                   f_t;

  assign tol_sq = snft_pkg::TOL_SQ_BITS'(sin_tol_q) * snft_pkg::TOL_SQ_BITS'(sin_tol_q);
  assign s_sum  = (SQW+2)'(d_sq[0]) + (SQW+2)'(d_sq[1]) + (SQW+2)'(d_sq[2]);

  snft_mul #(.AW(SQW), .BW(snft_pkg::TOL_SQ_BITS), .CW(CB)) u_tol (
    .clk_i (clk_i),
    .en_i  (pipe_en),
    .a_i   (d_lulv),
    .b_i   (tol_sq),
    .p_o   (f_t)
  );

  logic              e_v_q, f_v_q;
  logic [2:0]        e_sgn_q, f_sgn_q;
  snft_pkg::status_e e_st_q, f_st_q;
  logic [SQW-1:0]    e_s_q, f_s_q;
  logic [SQW-1:0]    e_x_q [3];
  logic [SQW-1:0]    f_x_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e_v_q <= 1'b0;
      f_v_q <= 1'b0;
    end else if (pipe_en) begin
      e_v_q <= d_v_q;
      f_v_q <= e_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      e_sgn_q <= d_sgn_q;
      e_st_q  <= d_st_q;
      e_s_q   <= s_sum[SQW-1:0];
      f_sgn_q <= e_sgn_q;
      f_st_q  <= e_st_q;
      f_s_q   <= e_s_q;
      for (int i = 0; i < 3; i++) begin
        e_x_q[i] <= d_sq[i];
        f_x_q[i] <= e_x_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage G: parallel test, s * 2^32 < sin_tol^2 * Lu * Lv. A zero cross
  // product also counts as parallel. Null results keep their status.
  // ---------------------------------------------------------------------
  logic              par_lt;
  logic              cross_zero;
  snft_pkg::status_e g_st;

  assign par_lt     = {f_s_q, {snft_pkg::TOL_SQ_BITS{1'b0}}} < f_t;
  assign cross_zero = (f_s_q == '0);

  always_comb begin
    if (f_st_q != snft_pkg::ST_DONE) begin
      g_st = f_st_q;
    end else if (par_lt || cross_zero) begin
      g_st = snft_pkg::ST_PARALLEL;
    end else begin
      g_st = snft_pkg::ST_DONE;
    end
  end

  logic              g_v_q;
  logic [2:0]        g_sgn_q;
  snft_pkg::status_e g_st_q;
  logic [SQW-1:0]    g_s_q;
  logic [SQW-1:0]    g_x_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      g_v_q <= 1'b0;
    end else if (pipe_en) begin
      g_v_q <= f_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      g_sgn_q <= f_sgn_q;
      g_st_q  <= g_st;
      g_s_q   <= f_s_q;
      for (int i = 0; i < 3; i++) begin
        g_x_q[i] <= f_x_q[i];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Root lanes: y = floor(|c_i| * 2^31 / |c|), exact, one bit per stage.
  // The status and the first sign ride along in lane zero.
  // ---------------------------------------------------------------------
  logic [QB-1:0] l_y   [3];
  logic [2:0]    l_v;
  logic [3:0]    l0_tag;
  logic          l1_tag, l2_tag;

  snft_root_lane #(.SW(SQW), .TW(4)) u_lane0 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (g_v_q),
    .x_i     (g_x_q[0]),
    .s_i     (g_s_q),
    .tag_i   ({logic'(g_st_q[2]), g_st_q[1:0], g_sgn_q[0]}),
    .valid_o (l_v[0]),
    .y_o     (l_y[0]),
    .tag_o   (l0_tag)
  );

  snft_root_lane #(.SW(SQW), .TW(1)) u_lane1 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (g_v_q),
    .x_i     (g_x_q[1]),
    .s_i     (g_s_q),
    .tag_i   (g_sgn_q[1]),
    .valid_o (l_v[1]),
    .y_o     (l_y[1]),
    .tag_o   (l1_tag)
  );

  snft_root_lane #(.SW(SQW), .TW(1)) u_lane2 (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (g_v_q),
    .x_i     (g_x_q[2]),
    .s_i     (g_s_q),
    .tag_i   (g_sgn_q[2]),
    .valid_o (l_v[2]),
    .y_o     (l_y[2]),
    .tag_o   (l2_tag)
  );

  // ---------------------------------------------------------------------
  // Output stage: q = round half away of y / 2, signed, zero unless done.
  // ---------------------------------------------------------------------
  snft_pkg::status_e       o_st;
  logic [2:0]              o_sgn;
  logic [QB:0]             q_wide [3];
  logic signed [NB-1:0]    o_n    [3];

  assign o_st  = snft_pkg::status_e'(l0_tag[3:1]);
  assign o_sgn = {l2_tag, l1_tag, l0_tag[0]};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q_wide[i] = ((QB+1)'(l_y[i]) + (QB+1)'(1)) >> 1;
      if (o_st != snft_pkg::ST_DONE) begin
        o_n[i] = '0;
      end else if (o_sgn[i]) begin
        o_n[i] = -$signed(NB'(q_wide[i]));
      end else begin
        o_n[i] = $signed(NB'(q_wide[i]));
      end
    end
  end

  snft_pkg::status_e    out_st_q;
  logic signed [NB-1:0] out_n_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (pipe_en) begin
      out_v_q <= &l_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      out_st_q <= o_st;
      for (int i = 0; i < 3; i++) begin
        out_n_q[i] <= o_n[i];
      end
    end
  end

  assign out_chan_o.valid    = out_v_q;
  assign out_chan_o.status   = out_st_q;
  assign out_chan_o.normal_x = out_n_q[0];
  assign out_chan_o.normal_y = out_n_q[1];
  assign out_chan_o.normal_z = out_n_q[2];

  // ---------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------
  `SNFT_ASSERT_IMP(a_stall_blocks_input, out_v_q && !out_chan_o.ready, !in_chan_i.ready, "input taken during output stall")
  `SNFT_ASSERT_IMP(a_zero_unless_done, out_v_q && (out_st_q != snft_pkg::ST_DONE), (out_n_q[0] == '0) && (out_n_q[1] == '0) && (out_n_q[2] == '0), "normal nonzero without done status")
  `SNFT_ASSERT_IMP(a_unit_bound, out_v_q, (out_n_q[0] <= snft_pkg::UNIT_ONE) && (out_n_q[0] >= -snft_pkg::UNIT_ONE) && (out_n_q[2] <= snft_pkg::UNIT_ONE) && (out_n_q[2] >= -snft_pkg::UNIT_ONE), "normal component beyond one")
  `SNFT_ASSERT_NXT(a_valid_travels, a_v_q && pipe_en, b_v_q, "valid bit lost between first stages")

endmodule

>>> tb/sv/surface_normal_from_tangents_unit_test.sv
// Self-checking bench for the surface normal unit: tangent pairs in, normals out.
// Depends on snft_pkg, the stream interfaces in snft_if and the unit's top level.
// A local exact-integer predictor checks status and normal of every transaction.
module surface_normal_from_tangents_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB          = snft_pkg::COMPONENT_BITS_DEF;
  localparam int CYCLE_LIMIT = 600000;
  // Pipeline depth plus margin, used before a register write and at the end.
  localparam int DRAIN_CYCLES = 60;

  typedef logic signed [CB-1:0] comp_t;

  typedef struct packed {
    comp_t du_x, du_y, du_z;
    comp_t dv_x, dv_y, dv_z;
  } tangents_t;

  typedef struct packed {
    snft_pkg::status_e                       status;
    logic signed [snft_pkg::NORMAL_BITS-1:0] nx, ny, nz;
  } normal_t;

  logic clk_i;
  logic rst_ni;

  logic                               psel, penable, pwrite;
  logic [snft_pkg::APB_ADDR_BITS-1:0] paddr;
  logic [snft_pkg::APB_DATA_BITS-1:0] pwdata;
  logic [snft_pkg::APB_DATA_BITS-1:0] prdata;
  logic                               pready;

  snft_in_if #(.CB(CB)) in_if ();
  snft_out_if           out_if ();

  surface_normal_from_tangents_unit #(.COMPONENT_BITS(CB)) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_chan_i  (in_if),
    .out_chan_o (out_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  // Shadow copies of the two registers; they only change while the unit is idle.
  logic [snft_pkg::TOL_BITS-1:0] tol_shadow;
  logic [snft_pkg::THR_BITS-1:0] thr_shadow;

  tangents_t pending_q[$];   // tangent pairs waiting to be offered
  normal_t   normal_q[$];    // predicted results, oldest first
  tangents_t cur_pair;
  int        gap_left;
  int        stall_left;
  bit        burst_mode;     // no idling on either side while set
  int        n_sent, n_checked, n_errors, n_settings;
  int        n_status[5];
  longint    cycles;

  // Largest q in [0, 2^30] such that (2q-1)^2 * s <= m^2 * 2^62, which is
  // round(m * 2^30 / sqrt(s)) with ties away from zero.
  function automatic logic [31:0] unit_magnitude(logic [191:0] m, logic [191:0] s);
    logic [191:0] bound, t;
    logic [63:0]  lo, hi, mid;
    bound = (m * m) << 62;
    lo = 0;
    hi = 64'd1 << 30;
    while (lo < hi) begin
      mid = lo + (hi - lo + 1) / 2;
      t = 192'(2 * mid - 1);
      t = t * t * s;
      if (t <= bound) lo = mid;
      else hi = mid - 1;
    end
    return lo[31:0];
  endfunction

  function automatic normal_t predict_normal(tangents_t p);
    logic signed [63:0] ux, uy, uz, vx, vy, vz;
    logic signed [63:0] c[3];
    logic [63:0]        len_u, len_v;
    logic [191:0]       cm[3];
    logic [191:0]       s, lhs, rhs;
    logic [31:0]        q;
    normal_t            r;
    ux = p.du_x; uy = p.du_y; uz = p.du_z;
    vx = p.dv_x; vy = p.dv_y; vz = p.dv_z;
    len_u = ux * ux + uy * uy + uz * uz;
    len_v = vx * vx + vy * vy + vz * vz;
    c[0] = uy * vz - uz * vy;
    c[1] = uz * vx - ux * vz;
    c[2] = ux * vy - uy * vx;
    s = '0;
    for (int i = 0; i < 3; i++) begin
      cm[i] = 192'(c[i] < 0 ? -c[i] : c[i]);
      s = s + cm[i] * cm[i];
    end
    r = '{status: snft_pkg::ST_DONE, nx: '0, ny: '0, nz: '0};
    if (len_u <= 64'(thr_shadow) && len_v <= 64'(thr_shadow)) begin
      r.status = snft_pkg::ST_BOTH_NULL;
    end else if (len_u <= 64'(thr_shadow)) begin
      r.status = snft_pkg::ST_U_NULL;
    end else if (len_v <= 64'(thr_shadow)) begin
      r.status = snft_pkg::ST_V_NULL;
    end else begin
      // Squared sine against squared tolerance, cross-multiplied to stay exact.
      lhs = s << 32;
      rhs = 192'(tol_shadow);
      rhs = rhs * rhs * 192'(len_u) * 192'(len_v);
      if (lhs < rhs || s == 0) r.status = snft_pkg::ST_PARALLEL;
      else begin
        q = unit_magnitude(cm[0], s); r.nx = (c[0] < 0) ? -q : q;
        q = unit_magnitude(cm[1], s); r.ny = (c[1] < 0) ? -q : q;
        q = unit_magnitude(cm[2], s); r.nz = (c[2] < 0) ? -q : q;
      end
    end
    return r;
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (burst_mode) return 0;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sender: offers the queued tangent pairs and records a prediction per
  // accepted transaction. Valid stays high while the unit holds ready low.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
      in_if.du_x <= '0; in_if.du_y <= '0; in_if.du_z <= '0;
      in_if.dv_x <= '0; in_if.dv_y <= '0; in_if.dv_z <= '0;
      gap_left = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        normal_q.push_back(predict_normal(cur_pair));
        n_sent++;
        gap_left = pick_gap();
      end
      if (in_if.valid && !in_if.ready) begin
        // Hold the offered pair.
      end else if (gap_left > 0) begin
        gap_left--;
        in_if.valid <= 1'b0;
      end else if (pending_q.size() > 0) begin
        cur_pair = pending_q.pop_front();
        in_if.du_x <= cur_pair.du_x; in_if.du_y <= cur_pair.du_y;
        in_if.du_z <= cur_pair.du_z; in_if.dv_x <= cur_pair.dv_x;
        in_if.dv_y <= cur_pair.dv_y; in_if.dv_z <= cur_pair.dv_z;
        in_if.valid <= 1'b1;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Receiver: checks every accepted result against the oldest prediction and
  // stalls at random.
  always @(posedge clk_i or negedge rst_ni) begin
    normal_t want;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        n_checked++;
        if (normal_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result status %0d normal %0d %0d %0d", $time,
                   out_if.status, out_if.normal_x, out_if.normal_y, out_if.normal_z);
        end else begin
          want = normal_q.pop_front();
          if (int'(want.status) < 5) n_status[int'(want.status)]++;
          if (out_if.status !== want.status) begin
            n_errors++;
            $display("%0t: status expected %0d actual %0d", $time, want.status,
                     out_if.status);
          end
          if (out_if.normal_x !== want.nx) begin
            n_errors++;
            $display("%0t: normal_x expected %0d actual %0d", $time, want.nx,
                     out_if.normal_x);
          end
          if (out_if.normal_y !== want.ny) begin
            n_errors++;
            $display("%0t: normal_y expected %0d actual %0d", $time, want.ny,
                     out_if.normal_y);
          end
          if (out_if.normal_z !== want.nz) begin
            n_errors++;
            $display("%0t: normal_z expected %0d actual %0d", $time, want.nz,
                     out_if.normal_z);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
        if (!burst_mode && $urandom_range(99) < 15) begin
          stall_left = ($urandom_range(9) == 0) ? $urandom_range(40, 8)
                                                 : $urandom_range(3, 1);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, normal_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic tangents_t pair_of(int ux, int uy, int uz, int vx, int vy, int vz);
    tangents_t p;
    p.du_x = comp_t'(ux); p.du_y = comp_t'(uy); p.du_z = comp_t'(uz);
    p.dv_x = comp_t'(vx); p.dv_y = comp_t'(vy); p.dv_z = comp_t'(vz);
    return p;
  endfunction

  function automatic int small_val(int lim);
    return $urandom_range(2 * lim) - lim;
  endfunction

  // Random tangent pair. Most are full-range or moderate general pairs; the
  // rest aim at the null and parallel branches with scaled or tiny vectors.
  function automatic tangents_t random_pair();
    tangents_t p;
    int k, m;
    case ($urandom_range(9))
      0, 1, 2: p = tangents_t'({$urandom, $urandom, $urandom, $urandom, $urandom});
      3, 4: p = pair_of(small_val(4095), small_val(4095), small_val(4095),
                        small_val(4095), small_val(4095), small_val(4095));
      5, 6: begin
        // Exactly or nearly parallel: v is a multiple of u plus a little noise.
        m = ($urandom_range(1)) ? 1023 : 3;
        k = small_val(1000);
        p = pair_of(small_val(m), small_val(m), small_val(m), 0, 0, 0);
        k = (k == 0) ? 1 : k;
        m = $urandom_range(2) ? 0 : 3;
        p.dv_x = comp_t'(p.du_x * k + small_val(m));
        p.dv_y = comp_t'(p.du_y * k + small_val(m));
        p.dv_z = comp_t'(p.du_z * k + small_val(m));
      end
      7: p = pair_of(small_val(2), small_val(2), small_val(2),
                     small_val(65535), small_val(65535), small_val(65535));
      8: p = pair_of(small_val(65535), small_val(65535), small_val(65535),
                     small_val(2), small_val(2), small_val(2));
      default: p = pair_of(small_val(300), small_val(300), small_val(300),
                           small_val(300), small_val(300), small_val(300));
    endcase
    return p;
  endfunction

  // Waits until every prediction has been answered, then lets the pipeline drain.
  // The queues are looked at on the falling edge, when the sender has settled.
  task automatic wait_idle();
    while (pending_q.size() > 0 || in_if.valid || normal_q.size() > 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write with a setup and an access phase; the upper data bits may carry junk the unit must ignore.
  task automatic write_reg(snft_pkg::cfg_reg_e idx,
                           logic [snft_pkg::APB_DATA_BITS-1:0] value);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= snft_pkg::APB_ADDR_BITS'(8 * int'(idx));
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == snft_pkg::REG_SIN_TOL) tol_shadow = value[snft_pkg::TOL_BITS-1:0];
    else thr_shadow = value[snft_pkg::THR_BITS-1:0];
  endtask

  task automatic run_phase(logic [snft_pkg::TOL_BITS-1:0] tol,
                           logic [snft_pkg::THR_BITS-1:0] thr,
                           int count, bit burst);
    wait_idle();
    write_reg(snft_pkg::REG_SIN_TOL, {$urandom, 16'h0, tol} & 64'hFFFF_FFFF_0000_FFFF |
              64'(tol));
    write_reg(snft_pkg::REG_NULL_THR, {16'($urandom_range(65535)), thr});
    n_settings++;
    burst_mode = burst;
    for (int i = 0; i < count; i++) pending_q.push_back(random_pair());
  endtask

  localparam int MX = 8388607;
  localparam int MN = -8388608;

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    tol_shadow = snft_pkg::SIN_TOL_RESET;
    thr_shadow = snft_pkg::NULL_THR_RESET;
    burst_mode = 1'b0;
    n_sent = 0; n_checked = 0; n_errors = 0; n_settings = 1; cycles = 0;
    foreach (n_status[i]) n_status[i] = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs under the reset register values: null cases, axes,
    // extremes, antiparallel and skewed vectors.
    pending_q.push_back(pair_of(0, 0, 0, 0, 0, 0));
    pending_q.push_back(pair_of(0, 0, 0, 1, 0, 0));
    pending_q.push_back(pair_of(1, 0, 0, 0, 0, 0));
    pending_q.push_back(pair_of(1, 0, 0, 0, 1, 0));
    pending_q.push_back(pair_of(0, 1, 0, 1, 0, 0));
    pending_q.push_back(pair_of(MX, MX, MX, MX, MX, MX));
    pending_q.push_back(pair_of(MN, MN, MN, MX, MX, MX));
    pending_q.push_back(pair_of(MN, 0, 0, 0, MN, 0));
    pending_q.push_back(pair_of(MX, MN, MX, MN, MX, MX));
    pending_q.push_back(pair_of(MN, MN, MN, MN, MX, MN));
    pending_q.push_back(pair_of(3, 4, 0, 0, 0, 5));
    pending_q.push_back(pair_of(1, 1, 0, 1, -1, 0));
    pending_q.push_back(pair_of(1000, 0, 0, 1000, 1, 0));
    pending_q.push_back(pair_of(MX, 1, -1, -1, MN, 1));
    pending_q.push_back(pair_of(-5, 7, 11, 13, -17, 19));
    for (int i = 0; i < 190; i++) pending_q.push_back(random_pair());

    // Zero tolerance: only an exactly zero cross product is parallel.
    wait_idle();
    write_reg(snft_pkg::REG_SIN_TOL, 64'd0);
    n_settings++;
    pending_q.push_back(pair_of(7, -3, 2, 7, -3, 2));
    pending_q.push_back(pair_of(7, -3, 2, -14, 6, -4));
    pending_q.push_back(pair_of(MX, MX, MX, MX, MX, MX - 1));
    for (int i = 0; i < 200; i++) pending_q.push_back(random_pair());

    run_phase(16'hFFFF, 48'd0, 210, 1'b0);
    run_phase(16'd66, 48'd1 << 20, 210, 1'b1);
    run_phase(16'd3000, 48'd12, 210, 1'b0);
    run_phase(snft_pkg::TOL_BITS'($urandom), 48'd1 << 40, 210, 1'b0);
    run_phase(16'd1, 48'hFFFF_FFFF_FFFF, 120, 1'b0);
    run_phase(16'd20000, 48'd3, 210, 1'b0);
    run_phase(snft_pkg::TOL_BITS'($urandom_range(255)), 48'(64'($urandom) << 8), 210, 1'b0);
    run_phase(16'd66, 48'd0, 150, 1'b1);

    wait_idle();
    $display("Sent %0d tangent pairs over %0d register settings, checked %0d results.",
             n_sent, n_settings, n_checked);
    $display("Status mix: done %0d, both null %0d, u null %0d, v null %0d, parallel %0d.",
             n_status[0], n_status[1], n_status[2], n_status[3], n_status[4]);
    if (n_errors == 0 && normal_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
